// ===== design/kpl_pkg.sv =====
// shared types, register indexes and key table for the keypad code lock
`timescale 1ns / 1ps

package kpl_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SECOND = 1'd1;

    localparam logic [6:0] CODE_FIRST_RESET  = 7'h30;
    localparam logic [6:0] CODE_SECOND_RESET = 7'h33;

    // scan geometry
    localparam int          ROW_W    = 2;
    localparam int          COL_W    = 4;
    localparam int          KEY_N    = 16;
    localparam int          KEY_IDX_W = 4;
    localparam logic [ROW_W-1:0] ROW_LAST = 2'd3;

    typedef logic [6:0] t_ascii;

    // input item: one column reading
    typedef struct packed {
        logic [COL_W-1:0] column_bits;
    } t_col_item;

    // result item: one per reading
    typedef struct packed {
        logic [ROW_W-1:0] row_drive;
        logic             key_valid;
        t_ascii           key_ascii;
        logic             code_done;
        logic             code_match;
    } t_key_item;

    // key position to ascii, bit 0 upward: * 0 # D 7 8 9 C 4 5 6 B 1 2 3 A
    function automatic t_ascii key_to_ascii(input logic [KEY_IDX_W-1:0] idx);
        t_ascii code;
        unique case (idx)
            4'd0:    code = 7'h2A;
            4'd1:    code = 7'h30;
            4'd2:    code = 7'h23;
            4'd3:    code = 7'h44;
            4'd4:    code = 7'h37;
            4'd5:    code = 7'h38;
            4'd6:    code = 7'h39;
            4'd7:    code = 7'h43;
            4'd8:    code = 7'h34;
            4'd9:    code = 7'h35;
            4'd10:   code = 7'h36;
            4'd11:   code = 7'h42;
            4'd12:   code = 7'h31;
            4'd13:   code = 7'h32;
            4'd14:   code = 7'h33;
            default: code = 7'h41;
        endcase
        return code;
    endfunction

endpackage

// ===== design/kpl_stream_if.sv =====
// valid/ready stream channel carrying one item per handshake
`timescale 1ns / 1ps

interface kpl_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/keypad_scan_debounce_code_lock.sv =====
// keypad scan, two-pass debounce, key encode and two-key code check
// a result item is registered into the output buffer when its column item is accepted
// throughput: one item per cycle, set by the single compute stage in front of
// a two-entry output buffer; input stalls only when both entries are full
// reset: synchronous active-low i_rst_n clears scan state, held key and buffer,
// and loads the code registers with '0' and '3'
`timescale 1ns / 1ps

module keypad_scan_debounce_code_lock (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kpl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kpl_stream_if.sink                    i_col,
    kpl_stream_if.source                  o_key
);

    // code registers
    kpl_pkg::t_ascii r_code_first;
    kpl_pkg::t_ascii r_code_second;

    // scan state
    logic [kpl_pkg::ROW_W-1:0] r_row;
    logic                      r_pass_second;
    logic [kpl_pkg::KEY_N-1:0] r_first_word;
    logic [kpl_pkg::KEY_N-1:0] r_second_word;
    logic [kpl_pkg::KEY_N-1:0] r_prev_stable;
    logic                      r_keys_entered;
    kpl_pkg::t_ascii           r_first_held;

    logic [kpl_pkg::ROW_W-1:0] n_row;
    logic                      n_pass_second;
    logic [kpl_pkg::KEY_N-1:0] n_first_word;
    logic [kpl_pkg::KEY_N-1:0] n_second_word;
    logic [kpl_pkg::KEY_N-1:0] n_prev_stable;
    logic                      n_keys_entered;
    kpl_pkg::t_ascii           n_first_held;

    // output buffer: head and skid entry
    kpl_pkg::t_key_item r_out;
    logic               r_out_valid;
    kpl_pkg::t_key_item r_skid;
    logic               r_skid_valid;

    logic               push;
    logic               pop;
    kpl_pkg::t_key_item n_item;

    logic [kpl_pkg::KEY_N-1:0]     row_mask;
    logic [kpl_pkg::KEY_N-1:0]     row_nib;
    logic [kpl_pkg::KEY_N-1:0]     stable;
    logic [kpl_pkg::KEY_N-1:0]     rising;
    logic [kpl_pkg::KEY_IDX_W-1:0] low_idx;
    logic                          scan_end;

    assign i_col.ready = !r_skid_valid;
    assign push        = i_col.valid && i_col.ready;
    assign pop         = r_out_valid && o_key.ready;

    assign o_key.valid = r_out_valid;
    assign o_key.data  = r_out;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_first  <= kpl_pkg::CODE_FIRST_RESET;
            r_code_second <= kpl_pkg::CODE_SECOND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kpl_pkg::CFG_CODE_FIRST:  r_code_first  <= i_cfg_data;
                kpl_pkg::CFG_CODE_SECOND: r_code_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // place the reading of row r at bits 15-4r .. 12-4r
    always_comb begin
        row_mask = {{(kpl_pkg::KEY_N-kpl_pkg::COL_W){1'b0}}, {kpl_pkg::COL_W{1'b1}}}
                   << ({2'd3 - r_row, 2'b00});
        row_nib  = {{(kpl_pkg::KEY_N-kpl_pkg::COL_W){1'b0}}, i_col.data.column_bits}
                   << ({2'd3 - r_row, 2'b00});
    end

    // lowest newly pressed key
    always_comb begin
        low_idx = '0;
        for (int i = kpl_pkg::KEY_N - 1; i >= 0; i--) begin
            if (rising[i]) begin
                low_idx = kpl_pkg::KEY_IDX_W'(i);
            end
        end
    end

    // next scan state and result item
    always_comb begin
        n_first_word   = r_first_word;
        n_second_word  = r_second_word;
        n_prev_stable  = r_prev_stable;
        n_keys_entered = r_keys_entered;
        n_first_held   = r_first_held;
        n_item         = '0;

        if (!r_pass_second) begin
            n_first_word = (r_first_word & ~row_mask) | row_nib;
        end else begin
            n_second_word = (r_second_word & ~row_mask) | row_nib;
        end

        scan_end = r_pass_second && (r_row == kpl_pkg::ROW_LAST);
        stable   = n_first_word & n_second_word;
        rising   = stable & ~r_prev_stable;

        if (scan_end) begin
            n_prev_stable = stable;
            if (rising != '0) begin
                n_item.key_valid = 1'b1;
                n_item.key_ascii = kpl_pkg::key_to_ascii(low_idx);
                n_prev_stable    = '0;
                if (!r_keys_entered) begin
                    n_first_held   = n_item.key_ascii;
                    n_keys_entered = 1'b1;
                end else begin
                    n_item.code_done  = 1'b1;
                    n_item.code_match = (r_first_held == r_code_first) &&
                                        (n_item.key_ascii == r_code_second);
                    n_keys_entered    = 1'b0;
                end
            end
        end

        n_pass_second    = (r_row == kpl_pkg::ROW_LAST) ? !r_pass_second : r_pass_second;
        n_row            = r_row + 1'b1;
        n_item.row_drive = n_row;
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row          <= '0;
            r_pass_second  <= 1'b0;
            r_first_word   <= '0;
            r_second_word  <= '0;
            r_prev_stable  <= '0;
            r_keys_entered <= 1'b0;
            r_first_held   <= '0;
        end else if (push) begin
            r_row          <= n_row;
            r_pass_second  <= n_pass_second;
            r_first_word   <= n_first_word;
            r_second_word  <= n_second_word;
            r_prev_stable  <= n_prev_stable;
            r_keys_entered <= n_keys_entered;
            r_first_held   <= n_first_held;
        end
    end

    // two-entry output buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_out <= n_item;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                r_out       <= n_item;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_item;
                r_skid_valid <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    // skid entry is only used behind a full head entry
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while head entry empty");

    // a completed entry always carries its key
    a_done_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key.valid && o_key.data.code_done) |-> o_key.data.key_valid)
        else $error("code_done without key_valid");

    // keys are only reported at the end of a scan, so the next row is row 0
    a_key_at_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key.valid && o_key.data.key_valid) |-> (o_key.data.row_drive == '0))
        else $error("key reported outside scan end");

    // a full buffer that is not drained holds off the input
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !o_key.ready) |=> !i_col.ready)
        else $error("input ready while output buffer full");
`endif

endmodule
